@@ sv/p1305_pkg.sv @@
// Shared types and constants for the Poly1305 MAC core.
// No dependencies; every other file of the core imports this package.
package p1305_pkg;

    localparam int LIMBS       = 5;
    localparam int LIMB_W      = 26;
    localparam int ACC_W       = 27;
    localparam int H_W         = 28;
    localparam int R5_W        = 29;
    localparam int PROD_W      = 57;
    localparam int SUM_W       = 64;
    localparam int CARRY_W     = SUM_W - LIMB_W;
    localparam int WORD_W      = 64;
    localparam int TAG_W       = 128;
    localparam int BLOCK_BYTES = 16;
    localparam int COUNT_W     = 5;
    localparam int MODE_W      = 2;
    localparam int COL_W       = 3;

    localparam logic [LIMB_W-1:0]  CLAMP_R1   = 26'h3ffff03;
    localparam logic [LIMB_W-1:0]  CLAMP_R2   = 26'h3ffc0ff;
    localparam logic [LIMB_W-1:0]  CLAMP_R3   = 26'h3f03fff;
    localparam logic [LIMB_W-1:0]  CLAMP_R4   = 26'h00fffff;
    localparam logic [31:0]        LIMB_MASK  = 32'h3ffffff;
    localparam logic [31:0]        LIMB_RANGE = 32'h4000000;
    localparam logic [COUNT_W-1:0] FULL_BYTES = 5'd16;

    typedef enum logic [MODE_W-1:0] {
        MODE_ABSORB = 2'd0,
        MODE_FINISH = 2'd1,
        MODE_PEEK   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_R_LOW  = 2'd0,
        CFG_R_HIGH = 2'd1,
        CFG_S_LOW  = 2'd2,
        CFG_S_HIGH = 2'd3
    } t_cfg_idx;

    typedef logic [COL_W-1:0]                t_col;
    typedef logic [LIMBS-1:0][ACC_W-1:0]     t_acc_vec;
    typedef logic [LIMBS-1:0][H_W-1:0]       t_hvec;
    typedef logic [LIMBS-1:0][LIMB_W-1:0]    t_rvec;
    typedef logic [LIMBS-1:1][R5_W-1:0]      t_r5vec;

endpackage

@@ sv/p1305_if.sv @@
// Request and tag channels of the Poly1305 MAC core (valid/ready).
// Depends on p1305_pkg for field widths.
interface p1305_msg_if;
    import p1305_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    block_low;
    logic [WORD_W-1:0]    block_high;
    logic [COUNT_W-1:0]   byte_count;
    logic [MODE_W-1:0]    tag_mode;

    modport source (output valid, block_low, block_high, byte_count, tag_mode, input ready);
    modport sink   (input valid, block_low, block_high, byte_count, tag_mode, output ready);
endinterface

interface p1305_tag_if;
    import p1305_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    tag_low;
    logic [WORD_W-1:0]    tag_high;

    modport source (output valid, tag_low, tag_high, input ready);
    modport sink   (input valid, tag_low, tag_high, output ready);
endinterface

@@ sv/poly1305_mac_core.sv @@
// Poly1305 one-time authenticator. A request carries one 16-byte little-endian
// block, a byte count (0 absorbs nothing, 1..15 a padded short block, 16 or more
// a full block) and a tag mode (absorb, finish and clear, peek). The user must
// write the key halves r and s through the configuration port only while the core
// is idle; the core does not enforce this. r is clamped inside. An absorbed block
// is accepted, passes through the five-multiplier column bank (one product column
// per pass, carries folded in as the columns are summed) and ends with the final
// carry into limb 0. A tag adds a start step, the three-stage finalization
// pipeline and an emit step, which stalls while an unread tag is held; a request
// with no block and no tag returns to idle. One request is worked at a time; a
// finished tag waits in the output register while the next request is taken.
// Depends on p1305_pkg, p1305_if, p1305_mac_bank and p1305_tag.
module poly1305_mac_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    p1305_msg_if.sink                    i_msg,
    p1305_tag_if.source                  o_tag,
    input  logic                         i_cfg_we,
    input  p1305_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [p1305_pkg::WORD_W-1:0] i_cfg_data
);
    import p1305_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_FOLD = 6'b000100,
        S_TAG  = 6'b001000,
        S_WAIT = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state              r_state;
    t_col                r_cnt;
    t_acc_vec            r_acc;
    logic                r_tagreq;
    logic                r_clear;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_r_low;
    logic [WORD_W-1:0]   r_r_high;
    logic [WORD_W-1:0]   r_s_low;
    logic [WORD_W-1:0]   r_s_high;
    t_hvec               r_h;
    t_rvec               r_r;
    t_r5vec              r_r5;
    logic [CARRY_W-1:0]  r_carry;
    logic [WORD_W-1:0]   r_tag_low;
    logic [WORD_W-1:0]   r_tag_high;

    t_hvec               n_h;
    t_rvec               n_r;
    t_r5vec              n_r5;
    logic                accept;
    logic [COUNT_W-1:0]  cnt_sat;
    logic                want_tag;
    logic [TAG_W-1:0]    msg_pad;
    logic [SUM_W-1:0]    col_sum;
    logic [CARRY_W+3:0]  fold;
    logic                tag_start;
    logic                tag_done;
    logic [TAG_W-1:0]    tag_val;
    logic                load_out;

    assign accept    = i_msg.valid && i_msg.ready;
    assign cnt_sat   = (i_msg.byte_count > FULL_BYTES) ? FULL_BYTES : i_msg.byte_count;
    assign want_tag  = (i_msg.tag_mode == MODE_FINISH) || (i_msg.tag_mode == MODE_PEEK);
    assign tag_start = (r_state == S_TAG);
    assign load_out  = (r_state == S_EMIT) && (!r_out_valid || o_tag.ready);
    assign fold      = (CARRY_W+4)'(r_acc[0]) + (CARRY_W+4)'({r_carry, 2'b00})
                     + (CARRY_W+4)'(r_carry);

    always_comb begin
        logic [TAG_W-1:0] msg_in;
        logic [TAG_W-1:0] key;
        msg_in = {i_msg.block_high, i_msg.block_low};
        for (int b = 0; b < BLOCK_BYTES; b++) begin
            if (COUNT_W'(b) < cnt_sat) begin
                msg_pad[8*b +: 8] = msg_in[8*b +: 8];
            end else if (COUNT_W'(b) == cnt_sat) begin
                msg_pad[8*b +: 8] = 8'h01;
            end else begin
                msg_pad[8*b +: 8] = 8'h00;
            end
        end
        n_h[0] = H_W'(r_acc[0]) + H_W'(msg_pad[25:0]);
        n_h[1] = H_W'(r_acc[1]) + H_W'(msg_pad[51:26]);
        n_h[2] = H_W'(r_acc[2]) + H_W'(msg_pad[77:52]);
        n_h[3] = H_W'(r_acc[3]) + H_W'(msg_pad[103:78]);
        n_h[4] = H_W'(r_acc[4]) + H_W'({cnt_sat == FULL_BYTES, msg_pad[127:104]});

        key    = {r_r_high, r_r_low};
        n_r[0] = key[25:0];
        n_r[1] = key[51:26] & CLAMP_R1;
        n_r[2] = key[77:52] & CLAMP_R2;
        n_r[3] = key[103:78] & CLAMP_R3;
        n_r[4] = LIMB_W'(key[127:104]) & CLAMP_R4;
        for (int k = 1; k < LIMBS; k++) begin
            n_r5[k] = (R5_W'(n_r[k]) << 2) + R5_W'(n_r[k]);
        end
    end

    p1305_mac_bank u_bank (
        .i_clk   (i_clk),
        .i_col   (r_cnt),
        .i_h     (r_h),
        .i_r     (r_r),
        .i_r5    (r_r5),
        .i_carry (r_carry),
        .o_sum   (col_sum)
    );

    p1305_tag u_tag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (tag_start),
        .i_acc   (r_acc),
        .i_s     ({r_s_high, r_s_low}),
        .o_done  (tag_done),
        .o_tag   (tag_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_acc       <= '0;
            r_tagreq    <= 1'b0;
            r_clear     <= 1'b0;
            r_out_valid <= 1'b0;
            r_r_low     <= '0;
            r_r_high    <= '0;
            r_s_low     <= '0;
            r_s_high    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_R_LOW:  r_r_low  <= i_cfg_data;
                    CFG_R_HIGH: r_r_high <= i_cfg_data;
                    CFG_S_LOW:  r_s_low  <= i_cfg_data;
                    CFG_S_HIGH: r_s_high <= i_cfg_data;
                    default:    r_r_low  <= r_r_low;
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_tag.valid && o_tag.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_tagreq <= want_tag;
                        r_clear  <= (i_msg.tag_mode == MODE_FINISH);
                        r_cnt    <= '0;
                        if (cnt_sat != '0) begin
                            r_state <= S_MUL;
                        end else if (want_tag) begin
                            r_state <= S_TAG;
                        end
                    end
                end
                S_MUL: begin
                    for (int k = 0; k < LIMBS; k++) begin
                        if (r_cnt == COL_W'(k + 1)) begin
                            r_acc[k] <= ACC_W'(col_sum[LIMB_W-1:0]);
                        end
                    end
                    if (r_cnt == COL_W'(LIMBS)) begin
                        r_state <= S_FOLD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FOLD: begin
                    r_acc[0] <= ACC_W'(fold[LIMB_W-1:0]);
                    r_acc[1] <= r_acc[1] + ACC_W'(fold[CARRY_W+3:LIMB_W]);
                    r_state  <= r_tagreq ? S_TAG : S_IDLE;
                end
                S_TAG: begin
                    if (r_clear) begin
                        r_acc <= '0;
                    end
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (tag_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_h     <= n_h;
            r_r     <= n_r;
            r_r5    <= n_r5;
            r_carry <= '0;
        end else if ((r_state == S_MUL) && (r_cnt != '0)) begin
            r_carry <= col_sum[SUM_W-1:LIMB_W];
        end
        if (load_out) begin
            r_tag_low  <= tag_val[WORD_W-1:0];
            r_tag_high <= tag_val[TAG_W-1:WORD_W];
        end
    end

    assign i_msg.ready    = (r_state == S_IDLE);
    assign o_tag.valid    = r_out_valid;
    assign o_tag.tag_low  = r_tag_low;
    assign o_tag.tag_high = r_tag_high;

`ifndef SYNTHESIS
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("tag presented without an emit step");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cnt <= COL_W'(LIMBS)))
        else $error("column counter out of range");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tag_done |-> (r_state == S_WAIT))
        else $error("tag pipeline finished outside the wait step");

    a_finish_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state == S_TAG) && $past(r_clear)) |-> (r_acc == '0))
        else $error("accumulator not cleared after finish");
`endif

endmodule

@@ sv/p1305_mac_bank.sv @@
// Shared multiplier bank: one column of the 5x5 limb product per cycle.
// Registers five limb products, then sums them with the incoming carry.
// Depends on p1305_pkg.
module p1305_mac_bank (
    input  logic                          i_clk,
    input  p1305_pkg::t_col               i_col,
    input  p1305_pkg::t_hvec              i_h,
    input  p1305_pkg::t_rvec              i_r,
    input  p1305_pkg::t_r5vec             i_r5,
    input  logic [p1305_pkg::CARRY_W-1:0] i_carry,
    output logic [p1305_pkg::SUM_W-1:0]   o_sum
);
    import p1305_pkg::*;

    logic [R5_W-1:0]   coef   [LIMBS];
    logic [PROD_W-1:0] r_prod [LIMBS];

    always_comb begin
        case (i_col)
            3'd0: begin
                coef[0] = R5_W'(i_r[0]);
                coef[1] = i_r5[4];
                coef[2] = i_r5[3];
                coef[3] = i_r5[2];
                coef[4] = i_r5[1];
            end
            3'd1: begin
                coef[0] = R5_W'(i_r[1]);
                coef[1] = R5_W'(i_r[0]);
                coef[2] = i_r5[4];
                coef[3] = i_r5[3];
                coef[4] = i_r5[2];
            end
            3'd2: begin
                coef[0] = R5_W'(i_r[2]);
                coef[1] = R5_W'(i_r[1]);
                coef[2] = R5_W'(i_r[0]);
                coef[3] = i_r5[4];
                coef[4] = i_r5[3];
            end
            3'd3: begin
                coef[0] = R5_W'(i_r[3]);
                coef[1] = R5_W'(i_r[2]);
                coef[2] = R5_W'(i_r[1]);
                coef[3] = R5_W'(i_r[0]);
                coef[4] = i_r5[4];
            end
            3'd4: begin
                coef[0] = R5_W'(i_r[4]);
                coef[1] = R5_W'(i_r[3]);
                coef[2] = R5_W'(i_r[2]);
                coef[3] = R5_W'(i_r[1]);
                coef[4] = R5_W'(i_r[0]);
            end
            default: begin
                for (int j = 0; j < LIMBS; j++) begin
                    coef[j] = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < LIMBS; j++) begin
            r_prod[j] <= PROD_W'(i_h[j]) * PROD_W'(coef[j]);
        end
    end

    always_comb begin
        o_sum = SUM_W'(i_carry);
        for (int j = 0; j < LIMBS; j++) begin
            o_sum = o_sum + SUM_W'(r_prod[j]);
        end
    end

endmodule

@@ sv/p1305_tag.sv @@
// Tag finalization: normalize h, reduce mod 2^130-5, add the s pad.
// Three-stage pipeline, output held until the next start. Depends on p1305_pkg.
module p1305_tag (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  p1305_pkg::t_acc_vec         i_acc,
    input  logic [p1305_pkg::TAG_W-1:0] i_s,
    output logic                        o_done,
    output logic [p1305_pkg::TAG_W-1:0] o_tag
);
    import p1305_pkg::*;

    logic             r_v1;
    logic             r_v2;
    logic             r_v3;
    t_acc_vec         r_h1;
    t_acc_vec         n_h1;
    logic [TAG_W-1:0] r_pre;
    logic [TAG_W-1:0] n_pre;
    logic [TAG_W-1:0] r_tag;

    always_comb begin
        logic [31:0] a0, a1, a2, a3, a4, c;
        a0 = 32'(i_acc[0]);
        a1 = 32'(i_acc[1]);
        a2 = 32'(i_acc[2]);
        a3 = 32'(i_acc[3]);
        a4 = 32'(i_acc[4]);
        c  = a1 >> 26; a1 = a1 & LIMB_MASK;
        a2 = a2 + c;   c  = a2 >> 26; a2 = a2 & LIMB_MASK;
        a3 = a3 + c;   c  = a3 >> 26; a3 = a3 & LIMB_MASK;
        a4 = a4 + c;   c  = a4 >> 26; a4 = a4 & LIMB_MASK;
        a0 = a0 + (c << 2) + c;
        c  = a0 >> 26; a0 = a0 & LIMB_MASK;
        a1 = a1 + c;
        n_h1[0] = ACC_W'(a0);
        n_h1[1] = ACC_W'(a1);
        n_h1[2] = ACC_W'(a2);
        n_h1[3] = ACC_W'(a3);
        n_h1[4] = ACC_W'(a4);
    end

    always_comb begin
        logic [31:0] h0, h1, h2, h3, h4, g0, g1, g2, g3, g4, c;
        logic        sel;
        logic [63:0] lo, hi;
        h0 = 32'(r_h1[0]);
        h1 = 32'(r_h1[1]);
        h2 = 32'(r_h1[2]);
        h3 = 32'(r_h1[3]);
        h4 = 32'(r_h1[4]);
        g0 = h0 + 32'd5; c = g0 >> 26; g0 = g0 & LIMB_MASK;
        g1 = h1 + c;     c = g1 >> 26; g1 = g1 & LIMB_MASK;
        g2 = h2 + c;     c = g2 >> 26; g2 = g2 & LIMB_MASK;
        g3 = h3 + c;     c = g3 >> 26; g3 = g3 & LIMB_MASK;
        g4 = h4 + c - LIMB_RANGE;
        sel = ~g4[31];
        if (sel) begin
            h0 = g0; h1 = g1; h2 = g2; h3 = g3; h4 = g4;
        end
        lo = 64'(h0) | (64'(h1) << 26) | (64'(h2) << 52);
        hi = (64'(h2) >> 12) | (64'(h3) << 14) | (64'(h4) << 40);
        n_pre = {hi, lo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_h1 <= n_h1;
        end
        if (r_v1) begin
            r_pre <= n_pre;
        end
        if (r_v2) begin
            r_tag <= r_pre + i_s;
        end
    end

    assign o_done = r_v3;
    assign o_tag  = r_tag;

endmodule
